// ----- rtl/khmm_pkg.sv -----
// ----------------------------------------------------------------------------
// khmm_pkg
// Shared types and constants for the key histogram min/max tracker.
// ----------------------------------------------------------------------------
package khmm_pkg;

    localparam int KEY_W     = 7;
    localparam int NUM_KEYS  = 1 << KEY_W;
    localparam int COUNT_W   = 16;
    localparam int MINMAX_W  = KEY_W + 1;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [NUM_KEYS-1:0] keyvec_t;
    typedef logic [MINMAX_W-1:0] minmax_t;

    localparam count_t  COUNT_MAX = '1;
    localparam key_t    KEY_MAX   = key_t'(NUM_KEYS - 1);
    localparam minmax_t EMPTY_MIN = minmax_t'(NUM_KEYS);
    localparam minmax_t EMPTY_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MOVE   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0] command;
        key_t       key;
        key_t       old_key;
    } item_t;

    typedef struct packed {
        logic   en;
        key_t   addr;
        count_t data;
    } wr_req_t;

    typedef struct packed {
        minmax_t min_key;
        minmax_t max_key;
        logic    min_changed;
        logic    max_changed;
        logic    count_overflow;
    } result_t;

endpackage

// ----- rtl/khmm_count_bank.sv -----
// ----------------------------------------------------------------------------
// khmm_count_bank
// Count memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module khmm_count_bank (
    input  logic              clk,
    input  logic              we,
    input  khmm_pkg::key_t    waddr,
    input  khmm_pkg::count_t  wdata,
    input  logic              re,
    input  khmm_pkg::key_t    raddr0,
    input  khmm_pkg::key_t    raddr1,
    output khmm_pkg::count_t  rdata0,
    output khmm_pkg::count_t  rdata1
);
    import khmm_pkg::*;

    count_t mem [NUM_KEYS];
    count_t rdata0_reg;
    count_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ----- rtl/khmm_update.sv -----
// ----------------------------------------------------------------------------
// khmm_update
// Single-pass update: count lookup with bypass, remove/add halves, flags,
// new presence vector and min/max priority encoding.
// ----------------------------------------------------------------------------
module khmm_update (
    input  logic              valid,
    input  khmm_pkg::item_t   item,
    input  khmm_pkg::keyvec_t present,
    input  khmm_pkg::keyvec_t sel,
    input  khmm_pkg::count_t  a_rd_key,
    input  khmm_pkg::count_t  a_rd_old,
    input  khmm_pkg::count_t  r_rd_key,
    input  khmm_pkg::count_t  r_rd_old,
    input  khmm_pkg::wr_req_t fwd_a,
    input  khmm_pkg::wr_req_t fwd_r,
    output khmm_pkg::keyvec_t present_next,
    output khmm_pkg::keyvec_t sel_next,
    output khmm_pkg::wr_req_t a_wr,
    output khmm_pkg::wr_req_t r_wr,
    output khmm_pkg::result_t res
);
    import khmm_pkg::*;

    localparam keyvec_t ALL_ONES = '1;

    // latest count of a key: not present reads zero, else last write wins
    function automatic count_t lookup(
        input logic    pres,
        input logic    use_a,
        input key_t    k,
        input wr_req_t fa,
        input wr_req_t fr,
        input count_t  a_rd,
        input count_t  r_rd
    );
        count_t c;
        priority if (!pres)
            c = '0;
        else if (fa.en && fa.addr == k)
            c = fa.data;
        else if (fr.en && fr.addr == k)
            c = fr.data;
        else if (use_a)
            c = a_rd;
        else
            c = r_rd;
        return c;
    endfunction

    count_t  cnt_key;
    count_t  cnt_old;
    count_t  rm_cnt;
    count_t  add_data;
    key_t    rm_k;
    logic    rm_en;
    logic    add_en;
    keyvec_t pres_mid;
    keyvec_t pres_out;
    keyvec_t le_add;
    keyvec_t le_rm;
    minmax_t min_v;
    minmax_t max_v;
    logic    mn;
    logic    mx;
    logic    ovf;

    always_comb
    begin
        cnt_key = lookup(present[item.key], sel[item.key], item.key,
                         fwd_a, fwd_r, a_rd_key, r_rd_key);
        cnt_old = lookup(present[item.old_key], sel[item.old_key], item.old_key,
                         fwd_a, fwd_r, a_rd_old, r_rd_old);

        rm_en  = 1'b0;
        add_en = 1'b0;
        rm_k   = item.key;
        rm_cnt = cnt_key;
        unique case (item.command)
            CMD_ADD:
            begin
                add_en = 1'b1;
            end
            CMD_REMOVE:
            begin
                rm_en = 1'b1;
            end
            CMD_MOVE:
            begin
                rm_en  = (item.key != item.old_key);
                add_en = (item.key != item.old_key);
                rm_k   = item.old_key;
                rm_cnt = cnt_old;
            end
            default:
            begin
                rm_en  = 1'b0;
                add_en = 1'b0;
            end
        endcase

        le_rm  = ALL_ONES >> (KEY_MAX - rm_k);
        le_add = ALL_ONES >> (KEY_MAX - item.key);

        mn       = 1'b0;
        mx       = 1'b0;
        ovf      = 1'b0;
        pres_mid = present;
        sel_next = sel;
        r_wr     = '0;
        a_wr     = '0;
        add_data = '0;

        // remove half
        if (valid && rm_en && present[rm_k])
        begin
            if (rm_cnt == count_t'(1))
            begin
                mn             = ~|(present & ~(ALL_ONES << rm_k));
                mx             = ~|(present & ~le_rm);
                pres_mid[rm_k] = 1'b0;
            end
            r_wr           = '{en: 1'b1, addr: rm_k, data: count_t'(rm_cnt - count_t'(1))};
            sel_next[rm_k] = 1'b0;
        end

        pres_out = pres_mid;

        // add half, compared against the set left by the remove half
        if (valid && add_en)
        begin
            mn = mn | ~|(pres_mid & le_add);
            mx = mx | ~|(pres_mid & (ALL_ONES << item.key));
            if (cnt_key == COUNT_MAX)
            begin
                ovf      = 1'b1;
                add_data = COUNT_MAX;
            end
            else
            begin
                add_data = count_t'(cnt_key + count_t'(1));
            end
            a_wr               = '{en: 1'b1, addr: item.key, data: add_data};
            sel_next[item.key] = 1'b1;
            pres_out[item.key] = 1'b1;
        end

        min_v = EMPTY_MIN;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (pres_out[i])
                min_v = minmax_t'(i);
        end
        max_v = EMPTY_MAX;
        for (int j = 0; j < NUM_KEYS; j++)
        begin
            if (pres_out[j])
                max_v = minmax_t'(j);
        end

        present_next = pres_out;
        res = '{min_key: min_v, max_key: max_v, min_changed: mn,
                max_changed: mx, count_overflow: ovf};
    end

endmodule

// ----- rtl/key_histogram_min_max_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// key_histogram_min_max_tracker_unit
// Per-key count histogram of 7-bit keys with running minimum and maximum.
// ----------------------------------------------------------------------------
// A request (add, remove or move of a key) is taken on every clock edge at
// which start is high; busy never rises, so one request per cycle is
// sustained. Each request gives exactly one result: done is high for one
// cycle, starting at the clock edge after the one that took the request, with
// min_key (128 when empty), max_key (-1 when empty) and the min/max-changed
// and overflow flags.
// The result cannot be held off, so it must be captured in that cycle.
// The taking edge loads the request register and the count memory read
// registers; the next edge closes the single update stage that writes counts,
// presence and the result register. There is no
// clearing pass after reset: a presence bit per key marks live counts, so
// the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module key_histogram_min_max_tracker_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          command,
    input  khmm_pkg::key_t                      key,
    input  khmm_pkg::key_t                      old_key,
    output logic                                done,
    output khmm_pkg::minmax_t                   min_key,
    output logic signed [khmm_pkg::MINMAX_W-1:0] max_key,
    output logic                                min_changed,
    output logic                                max_changed,
    output logic                                count_overflow
);
    import khmm_pkg::*;

    logic    accept;

    // request stage: captured alongside the count memory reads
    logic    s_valid_reg;
    item_t   s_item_reg;

    // presence bits double as valid bits for the count memories;
    // sel picks which bank holds the latest count of each key
    keyvec_t present_reg;
    keyvec_t present_next;
    keyvec_t sel_reg;
    keyvec_t sel_next;

    // last cycle's writes, bypassed past the registered memory reads
    wr_req_t fwd_a_reg;
    wr_req_t fwd_r_reg;
    wr_req_t a_wr;
    wr_req_t r_wr;

    count_t  a_rd_key;
    count_t  a_rd_old;
    count_t  r_rd_key;
    count_t  r_rd_old;

    result_t res;
    result_t res_reg;
    logic    done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // add half writes bank A, remove half writes bank R: a move then needs
    // one write on each, never two on the same port
    khmm_count_bank u_bank_add (
        .clk    (clk),
        .we     (a_wr.en),
        .waddr  (a_wr.addr),
        .wdata  (a_wr.data),
        .re     (accept),
        .raddr0 (key),
        .raddr1 (old_key),
        .rdata0 (a_rd_key),
        .rdata1 (a_rd_old)
    );

    khmm_count_bank u_bank_rem (
        .clk    (clk),
        .we     (r_wr.en),
        .waddr  (r_wr.addr),
        .wdata  (r_wr.data),
        .re     (accept),
        .raddr0 (key),
        .raddr1 (old_key),
        .rdata0 (r_rd_key),
        .rdata1 (r_rd_old)
    );

    khmm_update u_update (
        .valid        (s_valid_reg),
        .item         (s_item_reg),
        .present      (present_reg),
        .sel          (sel_reg),
        .a_rd_key     (a_rd_key),
        .a_rd_old     (a_rd_old),
        .r_rd_key     (r_rd_key),
        .r_rd_old     (r_rd_old),
        .fwd_a        (fwd_a_reg),
        .fwd_r        (fwd_r_reg),
        .present_next (present_next),
        .sel_next     (sel_next),
        .a_wr         (a_wr),
        .r_wr         (r_wr),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            present_reg <= '0;
            sel_reg     <= '0;
            fwd_a_reg   <= '0;
            fwd_r_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s_valid_reg <= accept;
            fwd_a_reg   <= a_wr;
            fwd_r_reg   <= r_wr;
            done_reg    <= s_valid_reg;
            if (s_valid_reg)
            begin
                present_reg <= present_next;
                sel_reg     <= sel_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_item_reg <= '{command: command, key: key, old_key: old_key};
        end
        if (s_valid_reg)
        begin
            res_reg <= res;
        end
    end

    assign done           = done_reg;
    assign min_key        = res_reg.min_key;
    assign max_key        = $signed(res_reg.max_key);
    assign min_changed    = res_reg.min_changed;
    assign max_changed    = res_reg.max_changed;
    assign count_overflow = res_reg.count_overflow;

`ifndef SYNTHESIS
    // every request in the update stage yields a result strobe next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |=> done_reg)
        else $error("result strobe missing after update stage");

    // one request never writes both banks at the same key
    a_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_a_reg.en && fwd_r_reg.en) |-> (fwd_a_reg.addr != fwd_r_reg.addr))
        else $error("both count banks written at the same key");

    // a non-empty set reports min not above max
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.min_key != EMPTY_MIN)
            |-> (!res_reg.max_key[MINMAX_W-1]
                 && res_reg.max_key[KEY_W-1:0] >= res_reg.min_key[KEY_W-1:0]))
        else $error("reported minimum above maximum");

    // empty minimum and empty maximum go together
    a_empty_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.min_key == EMPTY_MIN) |-> (res_reg.max_key == EMPTY_MAX))
        else $error("empty minimum with non-empty maximum");

    // a saturated add means the key, and so the set, is present
    a_ovf_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.count_overflow) |-> (res_reg.min_key != EMPTY_MIN))
        else $error("count overflow reported on an empty set");
`endif

endmodule
